// ===== design/line_edit_receive_buffer_top_assert.svh =====
// Assertion macros used by the checker in lerb_checker.sv.
`ifndef LINE_EDIT_RECEIVE_BUFFER_TOP_ASSERT_SVH
`define LINE_EDIT_RECEIVE_BUFFER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LERB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line edit receive buffer check failed");

// Consequent must hold in the cycle after the antecedent.
`define LERB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line edit receive buffer check failed");

`endif

// ===== design/lerb_pkg.sv =====
`timescale 1ns / 1ps
package lerb_pkg;

  // default number of byte cells
  localparam int unsigned DEPTH_DEF = 64;

  localparam int unsigned BYTE_W = 8;
  // width of the count fields on the ports
  localparam int unsigned CNT_W = 7;

  localparam logic [BYTE_W-1:0] BACKSPACE     = 8'h08;
  localparam logic [BYTE_W-1:0] TERMINATOR_RST = 8'd13;
  // most bytes pulled by one read word
  localparam logic [CNT_W-1:0]  MAX_PULL      = 7'd64;

  // opcodes of an input word
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // per-cycle control of the cell chain
  typedef struct packed {
    logic rotate;  // every cell takes its upper neighbor, cell 0 wraps to the top
    logic load;    // the selected cell takes the write byte
  } chain_ctl_t;

endpackage

// ===== design/lerb_cell.sv =====
`timescale 1ns / 1ps
module lerb_cell (
  input  logic                        clk,
  input  lerb_pkg::chain_ctl_t        ctl,
  input  logic                        sel,
  input  logic [lerb_pkg::BYTE_W-1:0] nbr,
  input  logic [lerb_pkg::BYTE_W-1:0] load_data,
  output logic [lerb_pkg::BYTE_W-1:0] q
);
  import lerb_pkg::*;

  logic [BYTE_W-1:0] q_next;

  // rotation wins over a load; the two never occur together
  always_comb begin
    q_next = q;
    if (ctl.rotate) begin
      q_next = nbr;
    end else if (ctl.load && sel) begin
      q_next = load_data;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ===== design/lerb_chain.sv =====
`timescale 1ns / 1ps
module lerb_chain #(
  parameter  int unsigned DEPTH = lerb_pkg::DEPTH_DEF,
  localparam int unsigned IW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  lerb_pkg::chain_ctl_t        ctl,
  input  logic [IW-1:0]               wr_idx,
  input  logic [lerb_pkg::BYTE_W-1:0] wr_data,
  output logic [lerb_pkg::BYTE_W-1:0] head
);
  import lerb_pkg::*;

  logic [BYTE_W-1:0] cell_q [DEPTH];

  // ring of cells, cell 0 holds the oldest byte
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lerb_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .sel       (wr_idx == IW'(i)),
      .nbr       (cell_q[(i + 1) % DEPTH]),
      .load_data (wr_data),
      .q         (cell_q[i])
    );
  end

  assign head = cell_q[0];

endmodule

// ===== design/line_edit_receive_buffer_top.sv =====
`timescale 1ns / 1ps
// Received byte: one word, in the output register the cycle after acceptance.
// Read: one word per pulled byte, each via the POP state into the output register;
//   the first after acceptance, each later one after the previous word is taken;
//   a pulled first terminator adds a full SCAN turn. Nothing pulled: one word.
// A terminator write holds off input until a full rescan of the ring (SCAN) is done.
// One word in flight; next word accepted the cycle after the last result is taken.
// rst (sync, active high) empties the buffer and sets terminator to 13; cells not cleared.
module line_edit_receive_buffer_top #(
  parameter int unsigned DEPTH = lerb_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: rx_byte[7:0], read_count[14:8], zero pad [15]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // s_tuser: opcode[0]
  input  logic [0:0]  s_tuser,
  // terminator register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [lerb_pkg::BYTE_W-1:0] cfg_data,
  // m_tdata: tx_byte[7:0], data_byte[15:8], cmd_length[22:16], used_count[29:23], pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  // m_tuser: tx_valid[0], data_valid[1]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);
  import lerb_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned MW = (CW > CNT_W) ? CW : CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_POP  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [BYTE_W-1:0] terminator, terminator_next;
  logic              dirty, dirty_next;
  logic [CW-1:0]     used, used_next;
  logic [CW-1:0]     cmd, cmd_next;
  logic              found, found_next;
  logic [IW-1:0]     scan_k, scan_k_next;
  logic [CNT_W-1:0]  remaining, remaining_next;
  logic              emit_pend, emit_pend_next;
  logic [BYTE_W-1:0] pull_byte, pull_byte_next;
  logic              pull_last, pull_last_next;

  // output register
  logic              o_txv, o_txv_next;
  logic [BYTE_W-1:0] o_txb, o_txb_next;
  logic              o_dv, o_dv_next;
  logic [BYTE_W-1:0] o_db, o_db_next;
  logic              o_last, o_last_next;
  logic [CNT_W-1:0]  o_cmd, o_cmd_next;
  logic [CNT_W-1:0]  o_used, o_used_next;

  chain_ctl_t        ctl;
  logic [BYTE_W-1:0] head;

  logic              in_op;
  logic [BYTE_W-1:0] in_byte;
  logic [CNT_W-1:0]  in_count;
  logic [CNT_W-1:0]  sat_count;
  logic [MW-1:0]     pull_count;

  assign in_op    = s_tuser[0];
  assign in_byte  = s_tdata[7:0];
  assign in_count = s_tdata[14:8];

  // pull count = min(read_count, limit, fill level)
  always_comb begin
    sat_count  = (in_count > MAX_PULL) ? MAX_PULL : in_count;
    pull_count = (MW'(sat_count) < MW'(used)) ? MW'(sat_count) : MW'(used);
  end

  assign s_tready  = (state == ST_IDLE) && !dirty && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign m_tvalid  = (state == ST_OUT);
  assign m_tdata   = {2'b00, o_used, o_cmd, o_db, o_txb};
  assign m_tuser   = {o_dv, o_txv};
  assign m_tlast   = o_last;

  // loads only happen below DEPTH, so the low bits select the cell
  lerb_chain #(.DEPTH(DEPTH)) u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .wr_idx  (IW'(used)),
    .wr_data (in_byte),
    .head    (head)
  );

  // sequencer
  always_comb begin
    state_next      = state;
    terminator_next = terminator;
    dirty_next      = dirty;
    used_next       = used;
    cmd_next        = cmd;
    found_next      = found;
    scan_k_next     = scan_k;
    remaining_next  = remaining;
    emit_pend_next  = emit_pend;
    pull_byte_next  = pull_byte;
    pull_last_next  = pull_last;
    o_txv_next      = o_txv;
    o_txb_next      = o_txb;
    o_dv_next       = o_dv;
    o_db_next       = o_db;
    o_last_next     = o_last;
    o_cmd_next      = o_cmd;
    o_used_next     = o_used;
    ctl.rotate      = 1'b0;
    ctl.load        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (cfg_valid) begin
          terminator_next = cfg_data;
          dirty_next      = 1'b1;
        end else if (dirty) begin
          // new terminator: search the whole buffer again
          dirty_next     = 1'b0;
          cmd_next       = '0;
          found_next     = 1'b0;
          scan_k_next    = '0;
          emit_pend_next = 1'b0;
          state_next     = ST_SCAN;
        end else if (s_tvalid) begin
          if (in_op == OP_RX) begin
            o_txv_next = 1'b1;
            if (in_byte == BACKSPACE) begin
              if (used != '0) begin
                used_next = used - 1'b1;
                // removed byte was the first terminator
                if (cmd == used) begin
                  cmd_next = '0;
                end
              end else begin
                o_txv_next = 1'b0;
              end
            end else if (used != CW'(DEPTH)) begin
              ctl.load  = 1'b1;
              used_next = used + 1'b1;
              if ((cmd == '0) && (in_byte == terminator)) begin
                cmd_next = used + 1'b1;
              end
            end
            o_txb_next     = o_txv_next ? in_byte : '0;
            o_dv_next      = 1'b0;
            o_db_next      = '0;
            o_last_next    = 1'b1;
            o_cmd_next     = CNT_W'(cmd_next);
            o_used_next    = CNT_W'(used_next);
            remaining_next = '0;
            state_next     = ST_OUT;
          end else if (pull_count == '0) begin
            o_txv_next     = 1'b0;
            o_txb_next     = '0;
            o_dv_next      = 1'b0;
            o_db_next      = '0;
            o_last_next    = 1'b1;
            o_cmd_next     = CNT_W'(cmd);
            o_used_next    = CNT_W'(used);
            remaining_next = '0;
            state_next     = ST_OUT;
          end else begin
            remaining_next = CNT_W'(pull_count);
            state_next     = ST_POP;
          end
        end
      end

      ST_POP: begin
        // take the head byte; rotating moves the next oldest into cell 0
        ctl.rotate     = 1'b1;
        pull_byte_next = head;
        pull_last_next = (remaining == CNT_W'(1));
        used_next      = used - 1'b1;
        remaining_next = remaining - 1'b1;
        if (cmd == CW'(1)) begin
          // first terminator leaves: find the next one
          cmd_next       = '0;
          found_next     = 1'b0;
          scan_k_next    = '0;
          emit_pend_next = 1'b1;
          state_next     = ST_SCAN;
        end else begin
          if (cmd != '0) begin
            cmd_next = cmd - 1'b1;
          end
          o_txv_next  = 1'b0;
          o_txb_next  = '0;
          o_dv_next   = 1'b1;
          o_db_next   = head;
          o_last_next = pull_last_next;
          o_cmd_next  = CNT_W'(cmd_next);
          o_used_next = CNT_W'(used_next);
          state_next  = ST_OUT;
        end
      end

      ST_SCAN: begin
        // one full turn of the ring, cell 0 compared each cycle
        ctl.rotate = 1'b1;
        if (!found && (CW'(scan_k) < used) && (head == terminator)) begin
          found_next = 1'b1;
          cmd_next   = CW'(scan_k) + 1'b1;
        end
        if (scan_k == IW'(DEPTH - 1)) begin
          scan_k_next = '0;
          if (emit_pend) begin
            emit_pend_next = 1'b0;
            o_txv_next     = 1'b0;
            o_txb_next     = '0;
            o_dv_next      = 1'b1;
            o_db_next      = pull_byte;
            o_last_next    = pull_last;
            o_cmd_next     = CNT_W'(cmd_next);
            o_used_next    = CNT_W'(used);
            state_next     = ST_OUT;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          scan_k_next = scan_k + 1'b1;
        end
      end

      ST_OUT: begin
        if (m_tready) begin
          state_next = (remaining != '0) ? ST_POP : ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      terminator <= TERMINATOR_RST;
      dirty      <= 1'b0;
      used       <= '0;
      cmd        <= '0;
      found      <= 1'b0;
      scan_k     <= '0;
      remaining  <= '0;
      emit_pend  <= 1'b0;
    end else begin
      state      <= state_next;
      terminator <= terminator_next;
      dirty      <= dirty_next;
      used       <= used_next;
      cmd        <= cmd_next;
      found      <= found_next;
      scan_k     <= scan_k_next;
      remaining  <= remaining_next;
      emit_pend  <= emit_pend_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pull_byte <= pull_byte_next;
    pull_last <= pull_last_next;
    o_txv     <= o_txv_next;
    o_txb     <= o_txb_next;
    o_dv      <= o_dv_next;
    o_db      <= o_db_next;
    o_last    <= o_last_next;
    o_cmd     <= o_cmd_next;
    o_used    <= o_used_next;
  end

endmodule

// ===== design/lerb_checker.sv =====
`timescale 1ns / 1ps
`include "line_edit_receive_buffer_top_assert.svh"
module lerb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // a result word holds until taken
  `LERB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

  // a pulled byte is never an echo at the same time
  `LERB_ASSERT_NOW(a_no_mixed, m_tvalid && m_tuser[1], !m_tuser[0])

  // only reads give more than one word
  `LERB_ASSERT_NOW(a_multi_is_read, m_tvalid && !m_tlast, m_tuser[1])

  // no new input word while a read still has words to give
  `LERB_ASSERT_NEXT(a_read_busy, m_tvalid && m_tready && !m_tlast, !s_tready)

  // one word at a time: ready drops after an accept
  `LERB_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

endmodule

bind line_edit_receive_buffer_top lerb_checker u_lerb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== bench/line_edit_receive_buffer_checker.sv =====
`timescale 1ns / 1ps
module line_edit_receive_buffer_checker #(
  parameter int unsigned DEPTH = lerb_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: rx_byte[7:0], read_count[14:8], zero pad [15]
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  // s_tuser: opcode[0]
  input  logic [0:0]  s_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [lerb_pkg::BYTE_W-1:0] cfg_data,
  // m_tdata: tx_byte[7:0], data_byte[15:8], cmd_length[22:16], used_count[29:23], pad
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  // m_tuser: tx_valid[0], data_valid[1]
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  output int          error_count,
  output int          pending_count
);

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       last;
    logic [6:0] cmd_length;
    logic [6:0] used_count;
  } buf_word_t;

  // shadow of the buffer contents and the terminator register
  logic [7:0]  cells [0:DEPTH-1];
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  logic [7:0]  term_value;

  buf_word_t expected_words[$];
  buf_word_t seen;
  buf_word_t oldest;

  // pointers run modulo 2*DEPTH so full and empty differ
  function automatic int unsigned fill_level();
    return (wr_ptr + 2 * DEPTH - rd_ptr) % (2 * DEPTH);
  endfunction

  // position plus one of the oldest stored terminator, 0 if none
  function automatic logic [6:0] first_term_pos();
    int unsigned n;
    int unsigned i;
    n = fill_level();
    for (i = 0; i < n; i++) begin
      if (cells[(rd_ptr + i) % DEPTH] == term_value) return 7'(i + 1);
    end
    return 7'd0;
  endfunction

  // one word as text for the mismatch report
  function automatic string word_str(input buf_word_t w);
    return $sformatf("txv=%0b txb=%02h dv=%0b db=%02h last=%0b len=%0d used=%0d",
                     w.tx_valid, w.tx_byte, w.data_valid, w.data_byte, w.last,
                     w.cmd_length, w.used_count);
  endfunction

  // queue one word; length and level reflect the state after its change
  task automatic queue_word(input logic txv, input logic [7:0] txb, input logic dv,
                            input logic [7:0] db, input logic lst);
    buf_word_t w;
    w.tx_valid   = txv;
    w.tx_byte    = txb;
    w.data_valid = dv;
    w.data_byte  = db;
    w.last       = lst;
    w.cmd_length = first_term_pos();
    w.used_count = 7'(fill_level());
    expected_words.push_back(w);
  endtask

  task automatic predict_buffer_words(input logic op, input logic [7:0] rx,
                                      input logic [6:0] cnt);
    logic        echo;
    int unsigned n_pull;
    int unsigned k;
    logic [7:0]  b;
    if (op == lerb_pkg::OP_RX) begin
      echo = 1'b1;
      if (rx == lerb_pkg::BACKSPACE) begin
        // backspace takes back the newest byte, silent when empty
        if (fill_level() != 0) wr_ptr = (wr_ptr + 2 * DEPTH - 1) % (2 * DEPTH);
        else echo = 1'b0;
      end else if (fill_level() < DEPTH) begin
        cells[wr_ptr % DEPTH] = rx;
        wr_ptr = (wr_ptr + 1) % (2 * DEPTH);
      end
      // a byte into a full buffer is dropped but still echoed
      queue_word(echo, echo ? rx : 8'h00, 1'b0, 8'h00, 1'b1);
    end else begin
      n_pull = (cnt > lerb_pkg::MAX_PULL) ? lerb_pkg::MAX_PULL : cnt;
      if (n_pull > fill_level()) n_pull = fill_level();
      if (n_pull == 0) begin
        queue_word(1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
      end else begin
        for (k = 0; k < n_pull; k++) begin
          b = cells[rd_ptr % DEPTH];
          rd_ptr = (rd_ptr + 1) % (2 * DEPTH);
          queue_word(1'b0, 8'h00, 1'b1, b, (k + 1 == n_pull));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      term_value = lerb_pkg::TERMINATOR_RST;
      wr_ptr = 0;
      rd_ptr = 0;
      error_count = 0;
      expected_words.delete();
    end else begin
      // output side first: a word never answers an item taken in the same cycle
      if (m_tvalid && m_tready) begin
        seen.tx_valid   = m_tuser[0];
        seen.tx_byte    = m_tdata[7:0];
        seen.data_valid = m_tuser[1];
        seen.data_byte  = m_tdata[15:8];
        seen.last       = m_tlast;
        seen.cmd_length = m_tdata[22:16];
        seen.used_count = m_tdata[29:23];
        if (expected_words.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: unexpected word %s", $time, word_str(seen));
        end else begin
          oldest = expected_words.pop_front();
          if (seen !== oldest) begin
            error_count++;
            if (error_count <= 10) begin
              $display("%0t: mismatch exp %s", $time, word_str(oldest));
              $display("%0t:          got %s", $time, word_str(seen));
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) term_value = cfg_data;
      if (s_tvalid && s_tready) predict_buffer_words(s_tuser[0], s_tdata[7:0], s_tdata[14:8]);
    end
    pending_count = expected_words.size();
  end

endmodule

// ===== bench/line_edit_receive_buffer_top_tb.sv =====
`timescale 1ns / 1ps
module line_edit_receive_buffer_top_tb;

  localparam int unsigned DEPTH = lerb_pkg::DEPTH_DEF;
  localparam int CYCLE_LIMIT = 20_000_000;

  logic        clk;
  logic        rst = 1'b1;
  // s_tdata: rx_byte[7:0], read_count[14:8], zero pad [15]
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'h0000;
  // s_tuser: opcode[0]
  logic [0:0]  s_tuser = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;
  // m_tdata: tx_byte[7:0], data_byte[15:8], cmd_length[22:16], used_count[29:23], pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  // m_tuser: tx_valid[0], data_valid[1]
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int          error_count;
  int          pending_count;
  int          cycle_count;
  int          send_idle_pct = 37;
  int          rcv_idle_pct = 70;
  logic [7:0]  term_now = lerb_pkg::TERMINATOR_RST;

  line_edit_receive_buffer_top #(.DEPTH(DEPTH)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  line_edit_receive_buffer_checker #(.DEPTH(DEPTH)) i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready = (rcv_idle_pct == 0) || ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("line_edit_receive_buffer_top_tb: done, errors");
    $finish;
  end

  // one input word; valid stays high into the next call unless a gap is taken
  task automatic send_word(input logic op, input logic [7:0] rx, input logic [6:0] cnt);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {1'b0, cnt, rx};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  // register writes only with the block idle
  task automatic write_terminator(input logic [7:0] value);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    term_now  = value;
  endtask

  function automatic logic [7:0] pick_byte(input int bs_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return term_now;
    if (r < 12 + bs_pct) return lerb_pkg::BACKSPACE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [6:0] pick_count(input logic short_reads);
    int r;
    r = $urandom_range(0, 99);
    if (short_reads) return 7'($urandom_range(1, 3));
    if (r < 5) return 7'd0;
    if (r < 15) return 7'($urandom_range(64, 127));
    if (r < 22) return lerb_pkg::MAX_PULL;
    return 7'($urandom_range(1, 12));
  endfunction

  // each segment picks filling, balanced or draining traffic at random
  task automatic random_items(input int total, input logic fill_first);
    int done;
    int seg_len;
    int write_pct;
    int k;
    done = 0;
    while (done < total) begin
      seg_len = fill_first ? 100 : $urandom_range(15, 90);
      if (seg_len > total - done) seg_len = total - done;
      case ($urandom_range(0, 2))
        0: write_pct = 95;
        1: write_pct = 60;
        default: write_pct = 30;
      endcase
      if (fill_first) write_pct = 95;
      fill_first = 1'b0;
      for (k = 0; k < seg_len; k++) begin
        if ($urandom_range(0, 99) < write_pct)
          send_word(lerb_pkg::OP_RX, pick_byte(write_pct > 90 ? 4 : 15),
                    7'($urandom_range(0, 127)));
        else
          send_word(lerb_pkg::OP_READ, 8'($urandom_range(0, 255)), pick_count(write_pct > 90));
        done++;
        // hold off until every word is out
        if (done == total / 2 || $urandom_range(0, 99) < 2) wait_drained();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset terminator (13)
    send_word(lerb_pkg::OP_READ, 8'h00, 7'd1);     // read on empty
    send_word(lerb_pkg::OP_RX, 8'h08, 7'd0);       // backspace on empty
    send_word(lerb_pkg::OP_READ, 8'hFF, 7'd0);     // count zero, empty
    send_word(lerb_pkg::OP_RX, 8'h00, 7'd127);
    send_word(lerb_pkg::OP_RX, 8'hFF, 7'd0);
    send_word(lerb_pkg::OP_RX, 8'h0D, 7'd64);
    send_word(lerb_pkg::OP_RX, 8'h5A, 7'd1);
    send_word(lerb_pkg::OP_RX, 8'h08, 7'd127);     // takes back 5A
    send_word(lerb_pkg::OP_READ, 8'h00, 7'd0);     // count zero, not empty
    send_word(lerb_pkg::OP_READ, 8'hAA, 7'd1);
    send_word(lerb_pkg::OP_READ, 8'h55, 7'd2);     // pulls the terminator
    send_word(lerb_pkg::OP_RX, 8'h0D, 7'd0);
    send_word(lerb_pkg::OP_RX, 8'h0D, 7'd0);
    send_word(lerb_pkg::OP_RX, 8'hAA, 7'd127);
    send_word(lerb_pkg::OP_RX, 8'h55, 7'd0);
    send_word(lerb_pkg::OP_READ, 8'hFF, 7'd127);   // above the pull limit
    send_word(lerb_pkg::OP_RX, 8'h41, 7'd0);
    send_word(lerb_pkg::OP_RX, 8'h0D, 7'd0);
    send_word(lerb_pkg::OP_RX, 8'h42, 7'd0);
    send_word(lerb_pkg::OP_READ, 8'h00, lerb_pkg::MAX_PULL);
    send_word(lerb_pkg::OP_READ, 8'h00, lerb_pkg::MAX_PULL);

    // sender 37 / receiver 70
    write_terminator(8'h00);
    random_items(90, 1'b1);
    write_terminator(8'hFF);
    random_items(80, 1'b0);

    // sender 70 / receiver 37
    wait_drained();
    send_idle_pct = 70;
    rcv_idle_pct  = 37;
    write_terminator(8'($urandom_range(0, 255)));
    random_items(80, 1'b1);
    write_terminator(lerb_pkg::BACKSPACE);
    random_items(70, 1'b0);

    // no idling
    wait_drained();
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    write_terminator(lerb_pkg::TERMINATOR_RST);
    random_items(80, 1'b1);
    write_terminator(8'($urandom_range(0, 255)));
    random_items(70, 1'b0);

    wait_drained();
    repeat (DEPTH + 8) @(negedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("line_edit_receive_buffer_top_tb: done, clean");
    end else begin
      $display("line_edit_receive_buffer_top_tb: done, errors");
    end
    $finish;
  end

endmodule
